[hw/rtl/spv_pkg.sv]
// Shared types, codes and helpers for the sample playback voice.
// Used by every module of the block; depends on nothing else.
package spv_pkg;

    // Input item kinds as they arrive on the item channel.
    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_REWIND = 2'd1,
        KIND_TICK   = 2'd2
    } kind_t;

    // Operations handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_REWIND,
        OP_TICK
    } op_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PLAY_RATE    = 3'd0,
        REG_LEVEL_GAIN   = 3'd1,
        REG_LEFT_WEIGHT  = 3'd2,
        REG_RIGHT_WEIGHT = 3'd3,
        REG_STEREO_MODE  = 3'd4,
        REG_FRAME_COUNT  = 3'd5
    } reg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Back end state machine.
    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL1,
        B_MUL2,
        B_DONE
    } back_state_t;

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    // Datapath widths: sample x gain, then x weight, then round off 27 bits.
    localparam int PROD1_W     = 33;
    localparam int PROD2_W     = 50;
    localparam int ROUND_SHIFT = 27;
    localparam int SCALED_W    = PROD2_W - ROUND_SHIFT;

    typedef struct packed {
        logic        [1:0]  kind;
        logic        [15:0] frame_index;
        logic signed [15:0] sample_left;
        logic signed [15:0] sample_right;
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic signed [15:0] current_sample;
        logic               ended;
    } out_item_t;

    typedef struct packed {
        logic signed [23:0] play_rate;
        logic        [15:0] level_gain;
        logic        [15:0] left_weight;
        logic        [15:0] right_weight;
        logic               stereo_mode;
        logic        [16:0] frame_count;
    } cfg_t;

    localparam logic signed [23:0] RESET_PLAY_RATE    = 24'sd65536;
    localparam logic        [15:0] RESET_LEVEL_GAIN   = 16'd4096;
    localparam logic        [15:0] RESET_LEFT_WEIGHT  = 16'd23170;
    localparam logic        [15:0] RESET_RIGHT_WEIGHT = 16'd23170;
    localparam logic               RESET_STEREO_MODE  = 1'b0;
    localparam logic        [16:0] RESET_FRAME_COUNT  = 17'd0;

    // One job in the queue. For a load the two halves are the samples to
    // store, for a tick they are the mix values.
    typedef struct packed {
        op_t                op;
        logic        [15:0] index;
        logic signed [15:0] left;
        logic signed [15:0] right;
    } job_t;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] value);
        logic signed [15:0] res;
        if (value > 24'sd32767)
        begin
            res = 16'sh7FFF;
        end
        else if (value < -24'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = value[15:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/sample_playback_voice_unit.sv]
// Top level of the sample playback voice: configuration registers and the
// front end, queue and back end. Depends on spv_pkg, spv_front, spv_queue, spv_back.
//
// Usage. Items enter on item/item_valid/item_stall; an item is taken at a
// clock edge with item_valid high and item_stall low. A load item writes one
// frame into the sample store, a rewind item moves the playhead to a whole
// frame, and a tick item produces one result on result/result_valid, which
// the receiver holds off with result_stall. Loads outside the store and
// items of unknown kind are taken and dropped. Registers are written through
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high, and writes are
// expected only while no item is in flight.
// Back end. Loads and rewinds are done by the back end while it is idle. A
// tick steps the back end through store read, gain multiply, pan multiply,
// and rounding with saturation into the result register; a tick that finds
// the playhead off the table skips both multiplies. The back end takes no
// new job until a tick's result has been written into the result register.
// A two-entry queue lets the input side keep accepting while the back end
// works or the result waits in its register under stall.
// Reset clears the playhead to zero, restores register defaults and empties
// the queue and result register; the store is not cleared.
module sample_playback_voice_unit #(
    parameter int MAX_FRAMES = 65536,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  spv_pkg::in_item_t                   item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output spv_pkg::out_item_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spv_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import spv_pkg::*;

    cfg_t cfg_reg;
    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    // The register file never holds off a write.
    assign cfg_ready = 1'b1;

    // Register writes; indexes past the list fall into the default arm.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.play_rate    <= RESET_PLAY_RATE;
            cfg_reg.level_gain   <= RESET_LEVEL_GAIN;
            cfg_reg.left_weight  <= RESET_LEFT_WEIGHT;
            cfg_reg.right_weight <= RESET_RIGHT_WEIGHT;
            cfg_reg.stereo_mode  <= RESET_STEREO_MODE;
            cfg_reg.frame_count  <= RESET_FRAME_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PLAY_RATE:    cfg_reg.play_rate    <= $signed(cfg_data[23:0]);
                REG_LEVEL_GAIN:   cfg_reg.level_gain   <= cfg_data[15:0];
                REG_LEFT_WEIGHT:  cfg_reg.left_weight  <= cfg_data[15:0];
                REG_RIGHT_WEIGHT: cfg_reg.right_weight <= cfg_data[15:0];
                REG_STEREO_MODE:  cfg_reg.stereo_mode  <= cfg_data[0];
                REG_FRAME_COUNT:  cfg_reg.frame_count  <= cfg_data[16:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // The front end decodes the item kind and drops what has no effect.
    spv_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // The queue decouples input acceptance from the multi-cycle back end.
    spv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // The back end owns the store, the playhead and the result register.
    spv_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .job          (pop_job),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[hw/rtl/spv_front.sv]
// Front end of the sample playback voice: accepts items and classifies them.
// Depends on spv_pkg. Feeds spv_queue.
module spv_front #(
    parameter int MAX_FRAMES = 65536
) (
    input  logic             item_valid,
    output logic             item_stall,
    input  spv_pkg::in_item_t item,
    output logic             push_valid,
    input  logic             push_ready,
    output spv_pkg::job_t    push_job
);
    import spv_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int IW = ((AW > 16) ? AW : 16) + 1;
    localparam logic [IW-1:0] FRAMES_W = IW'(MAX_FRAMES);

    logic          keep;
    logic [IW-1:0] index_w;

    assign index_w = IW'(item.frame_index);

    // Loads outside the store and unknown kinds are taken and dropped here.
    always_comb
    begin
        keep        = 1'b0;
        push_job.op = OP_TICK;
        unique case (item.kind)
            KIND_LOAD:
            begin
                keep        = (index_w < FRAMES_W);
                push_job.op = OP_LOAD;
            end
            KIND_REWIND:
            begin
                keep        = 1'b1;
                push_job.op = OP_REWIND;
            end
            KIND_TICK:
            begin
                keep        = 1'b1;
                push_job.op = OP_TICK;
            end
            default:
            begin
                keep        = 1'b0;
                push_job.op = OP_TICK;
            end
        endcase
    end

    always_comb
    begin
        push_job.index = item.frame_index;
        if (item.kind == KIND_LOAD)
        begin
            push_job.left  = item.sample_left;
            push_job.right = item.sample_right;
        end
        else
        begin
            push_job.left  = item.mix_left;
            push_job.right = item.mix_right;
        end
    end

    assign item_stall = !push_ready;
    assign push_valid = item_valid && keep;

endmodule

[hw/rtl/spv_queue.sv]
// Short job queue between the front and back ends of the playback voice.
// Depends on spv_pkg for the job type and depth.
module spv_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  spv_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output spv_pkg::job_t pop_job
);
    import spv_pkg::*;

    job_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg;
    logic [QUEUE_PTR_W:0]   fill_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (fill_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (QUEUE_PTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (QUEUE_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/spv_back.sv]
// Back end of the playback voice: sample store, playhead, scaling datapath
// and result register. Depends on spv_pkg; takes jobs from spv_queue.
module spv_back #(
    parameter int MAX_FRAMES = 65536,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spv_pkg::cfg_t      cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  spv_pkg::job_t      job,
    output logic               result_valid,
    input  logic               result_stall,
    output spv_pkg::out_item_t result
);
    import spv_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int KW = (AW + 1 > 17) ? AW + 1 : 17;
    localparam int PW = ((KW + FRAC_BITS > 24) ? KW + FRAC_BITS : 24) + 2;
    localparam int HW = PW - FRAC_BITS;
    localparam logic signed [PW-1:0] HALF = PW'(1 << (FRAC_BITS - 1));
    localparam logic signed [PROD2_W-1:0] ROUND_BIAS = PROD2_W'(1 << (ROUND_SHIFT - 1));

    logic [31:0] store_mem [MAX_FRAMES];

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [PW-1:0]      pos_reg;
    logic signed [PW-1:0]      pos_next;
    logic        [31:0]        rd_reg;
    logic signed [15:0]        mix_l_reg;
    logic signed [15:0]        mix_r_reg;
    logic                      ended_reg;
    logic signed [PROD1_W-1:0] p1l_reg;
    logic signed [PROD1_W-1:0] p1r_reg;
    logic signed [PROD2_W-1:0] p2l_reg;
    logic signed [PROD2_W-1:0] p2r_reg;
    logic                      out_valid_reg;
    out_item_t                 result_reg;

    logic [KW-1:0]        fc_w;
    logic [KW-1:0]        frames_w;
    logic [KW-1:0]        count;
    logic signed [PW-1:0] limit;
    logic signed [PW-1:0] round_pos;
    logic [HW-1:0]        whole;
    logic [HW-1:0]        last;
    logic [HW-1:0]        sel;
    logic [AW-1:0]        rd_addr;
    logic                 ended;
    logic                 take;
    logic                 take_load;
    logic                 take_tick;
    logic                 out_free;
    logic                 done_fire;

    logic signed [PROD2_W-1:0]  rnd_l;
    logic signed [PROD2_W-1:0]  rnd_r;
    logic signed [SCALED_W-1:0] sc_l;
    logic signed [SCALED_W-1:0] sc_r;
    logic signed [23:0]         sum_l;
    logic signed [23:0]         sum_r;
    out_item_t                  result_new;

    // Frame count beyond the store acts as a full store.
    assign fc_w     = KW'(cfg.frame_count);
    assign frames_w = KW'(MAX_FRAMES);
    assign count    = (fc_w > frames_w) ? frames_w : fc_w;
    assign limit    = $signed(PW'(count) << FRAC_BITS);

    assign ended = (!cfg.play_rate[23] && (pos_reg >= limit)) ||
                   (cfg.play_rate[23] && pos_reg[PW-1]);

    // Nearest frame, clamped to the table.
    assign round_pos = pos_reg + HALF;
    assign whole     = round_pos[PW-1] ? '0 : HW'(round_pos[PW-1:FRAC_BITS]);
    assign last      = HW'(count) - HW'(1);
    always_comb
    begin
        if (count == '0)
        begin
            sel = '0;
        end
        else if (whole > last)
        begin
            sel = last;
        end
        else
        begin
            sel = whole;
        end
    end
    assign rd_addr = sel[AW-1:0];

    assign out_free  = !out_valid_reg || !result_stall;
    assign take      = pop_valid && pop_ready;
    assign take_load = take && (job.op == OP_LOAD);
    assign take_tick = take && (job.op == OP_TICK);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take_tick)
                begin
                    state_next = ended ? B_DONE : B_MUL1;
                end
            end
            B_MUL1:
            begin
                state_next = B_MUL2;
            end
            B_MUL2:
            begin
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        pop_ready = 1'b0;
        done_fire = 1'b0;
        unique case (state_reg)
            B_IDLE:  pop_ready = 1'b1;
            B_MUL1:  pop_ready = 1'b0;
            B_MUL2:  pop_ready = 1'b0;
            B_DONE:  done_fire = out_free;
            default: pop_ready = 1'b0;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (take && (job.op == OP_REWIND))
        begin
            pos_next = $signed(PW'(job.index) << FRAC_BITS);
        end
        else if (take_tick && !ended)
        begin
            pos_next = pos_reg + PW'(cfg.play_rate);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (done_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample store: one write port for loads, one registered read for ticks.
    always_ff @(posedge clk)
    begin
        if (take_load)
        begin
            store_mem[AW'(job.index)] <= {job.right, job.left};
        end
        if (take_tick)
        begin
            rd_reg <= store_mem[rd_addr];
        end
    end

    // Scaling pipeline, stepped by the state machine.
    always_ff @(posedge clk)
    begin
        if (take_tick)
        begin
            mix_l_reg <= job.left;
            mix_r_reg <= job.right;
            ended_reg <= ended;
        end
        if (state_reg == B_MUL1)
        begin
            p1l_reg <= $signed(rd_reg[15:0]) * $signed({1'b0, cfg.level_gain});
            p1r_reg <= $signed(rd_reg[31:16]) * $signed({1'b0, cfg.level_gain});
        end
        if (state_reg == B_MUL2)
        begin
            p2l_reg <= p1l_reg * $signed({1'b0, cfg.left_weight});
            p2r_reg <= p1r_reg * $signed({1'b0, cfg.right_weight});
        end
        if (done_fire)
        begin
            result_reg <= result_new;
        end
    end

    assign rnd_l = p2l_reg + ROUND_BIAS;
    assign rnd_r = p2r_reg + ROUND_BIAS;
    assign sc_l  = rnd_l[PROD2_W-1:ROUND_SHIFT];
    assign sc_r  = rnd_r[PROD2_W-1:ROUND_SHIFT];
    assign sum_l = 24'(sc_l) + 24'(mix_l_reg);
    assign sum_r = 24'(sc_r) + 24'(mix_r_reg);

    always_comb
    begin
        if (ended_reg)
        begin
            result_new.left_out       = mix_l_reg;
            result_new.right_out      = mix_r_reg;
            result_new.current_sample = '0;
            result_new.ended          = 1'b1;
        end
        else
        begin
            result_new.left_out       = sat16(sum_l);
            result_new.right_out      = cfg.stereo_mode ? sat16(sum_r) : mix_r_reg;
            result_new.current_sample = rd_reg[15:0];
            result_new.ended          = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

[hw/rtl/spv_checker.sv]
// Port-level checks for the sample playback voice, bound to the top level.
// Depends on spv_pkg and sample_playback_voice_unit.
module spv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_stall,
    input spv_pkg::out_item_t result
);
    import spv_pkg::*;

    // A result held off by the receiver stays in place.
    property p_result_holds;
        @(posedge clk) disable iff (!rst_n)
            result_valid && result_stall |=> result_valid && $stable(result);
    endproperty
    a_result_holds: assert property (p_result_holds)
        else $error("result changed or dropped while stalled");

    // A tick that found the playhead off the table reads no sample.
    property p_ended_no_sample;
        @(posedge clk) disable iff (!rst_n)
            result_valid && result.ended |-> result.current_sample == 16'sd0;
    endproperty
    a_ended_no_sample: assert property (p_ended_no_sample)
        else $error("ended result carries a sample");

    // Reset leaves no result pending.
    property p_reset_clears;
        @(posedge clk) !rst_n |-> !result_valid;
    endproperty
    a_reset_clears: assert property (p_reset_clears)
        else $error("result valid during reset");

endmodule

bind sample_playback_voice_unit spv_checker u_spv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for sample_playback_voice_unit: directed and random
// items, checked against an in-bench predictor of the playback voice.
// Depends on spv_pkg and the RTL of the block; reads nothing else.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spv_pkg::*;

    // Block configuration as instantiated below.
    localparam int MAX_FRAMES = 65536;
    localparam int FRAC_BITS  = 16;

    // Codes that the package leaves unnamed: the fourth item kind, which the
    // block drops, and the two register indexes past the end of the list.
    localparam logic [1:0] KIND_UNKNOWN  = 2'd3;
    localparam logic [2:0] REG_BEYOND_LO = 3'd6;
    localparam logic [2:0] REG_BEYOND_HI = 3'd7;

    localparam int RATE_MAX      = 8388607;
    localparam int RATE_MIN      = -8388608;
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    logic      item_valid = 1'b0;
    logic      item_stall;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Percent chance per cycle that the sender holds off or the receiver stalls.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int errors = 0;
    int items_sent = 0;
    int ticks_checked = 0;
    int ended_seen = 0;
    int regs_written = 0;
    int unsigned cycle_count = 0;

    // Predictor state: the playhead, the register copies and the frames that
    // have been loaded so far. Only loaded frames are ever played.
    longint      play_head = 0;
    int          rate_q = 65536;
    int unsigned gain_q = 4096;
    int unsigned left_wt_q = 23170;
    int unsigned right_wt_q = 23170;
    bit          stereo_q = 1'b0;
    int unsigned count_q = 0;
    logic [31:0] frame_store [int];

    out_item_t expected_results [$];
    out_item_t want;

    sample_playback_voice_unit #(
        .MAX_FRAMES(MAX_FRAMES),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Tells whether the playhead is off the table for the next tick, and
    // otherwise which frame that tick reads: the nearest frame, clamped
    // into the valid part of the table.
    function automatic bit head_off_table(output int frame);
        longint span;
        longint rounded;
        span = (count_q > MAX_FRAMES) ? MAX_FRAMES : count_q;
        frame = 0;
        if ((rate_q >= 0 && play_head >= (span <<< FRAC_BITS)) ||
            (rate_q < 0 && play_head < 0))
        begin
            return 1'b1;
        end
        rounded = play_head + (longint'(1) <<< (FRAC_BITS - 1));
        frame = (rounded < 0) ? 0 : int'(rounded >>> FRAC_BITS);
        if (span == 0)
        begin
            frame = 0;
        end
        else if (frame > span - 1)
        begin
            frame = int'(span - 1);
        end
        return 1'b0;
    endfunction

    // Sample times gain times pan weight has 27 fraction bits; round to the
    // nearest integer with exact halves going up.
    function automatic longint scale_sample(logic signed [15:0] s, int unsigned weight);
        longint prod;
        prod = longint'(s) * longint'(gain_q) * longint'(weight);
        return (prod + (longint'(1) <<< 26)) >>> 27;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Applies one item to the predictor state; returns 1 with the expected
    // result filled in when the item is a tick.
    function automatic bit predict_item(in_item_t it, output out_item_t res);
        int frame;
        logic [31:0] word;
        logic signed [15:0] left_s;
        logic signed [15:0] right_s;
        res = '0;
        if (it.kind == KIND_LOAD)
        begin
            frame_store[int'(it.frame_index)] = {it.sample_right, it.sample_left};
            return 1'b0;
        end
        if (it.kind == KIND_REWIND)
        begin
            play_head = longint'(it.frame_index) <<< FRAC_BITS;
            return 1'b0;
        end
        if (it.kind != KIND_TICK)
        begin
            return 1'b0;
        end
        if (head_off_table(frame))
        begin
            res.left_out  = it.mix_left;
            res.right_out = it.mix_right;
            res.current_sample = '0;
            res.ended = 1'b1;
            return 1'b1;
        end
        word = frame_store[frame];
        left_s = word[15:0];
        right_s = word[31:16];
        res.left_out = clip16(longint'(it.mix_left) + scale_sample(left_s, left_wt_q));
        res.right_out = stereo_q ?
                        clip16(longint'(it.mix_right) + scale_sample(right_s, right_wt_q)) :
                        it.mix_right;
        res.current_sample = left_s;
        res.ended = 1'b0;
        play_head += rate_q;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Item driver and register writer
    // ------------------------------------------------------------------

    // Samples lean toward the extremes now and then so that saturation and
    // rounding at the edges get exercised in the random part too.
    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(19))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Every field random; the callers overwrite the ones that matter.
    function automatic in_item_t random_item(logic [1:0] kind);
        in_item_t it;
        it.kind = kind;
        it.frame_index = 16'($urandom());
        it.sample_left = 16'($urandom());
        it.sample_right = 16'($urandom());
        it.mix_left = 16'($urandom());
        it.mix_right = 16'($urandom());
        return it;
    endfunction

    // Predicts the item, then offers it until the block takes it. The sender
    // may hold off first; valid stays high from one item to the next when it
    // does not, so valid only ever gets one update per clock edge.
    task automatic send_item(in_item_t it);
        out_item_t res;
        if (predict_item(it, res))
        begin
            expected_results.push_back(res);
        end
        if (it.kind != KIND_UNKNOWN)
        begin
            items_sent++;
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct);
        end
        item <= it;
        item_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
    endtask

    task automatic send_load(logic [15:0] frame, logic signed [15:0] left_s,
                             logic signed [15:0] right_s);
        in_item_t it;
        it = random_item(KIND_LOAD);
        it.frame_index = frame;
        it.sample_left = left_s;
        it.sample_right = right_s;
        send_item(it);
    endtask

    task automatic send_rewind(logic [15:0] frame);
        in_item_t it;
        it = random_item(KIND_REWIND);
        it.frame_index = frame;
        send_item(it);
    endtask

    // A tick that would play a frame never loaded is preceded by a load of
    // that frame, so no tick ever reads an unwritten store entry.
    task automatic send_tick(logic signed [15:0] mix_l, logic signed [15:0] mix_r);
        in_item_t it;
        int frame;
        if (!head_off_table(frame) && !frame_store.exists(frame))
        begin
            send_load(frame[15:0], pick_sample(), pick_sample());
        end
        it = random_item(KIND_TICK);
        it.mix_left = mix_l;
        it.mix_right = mix_r;
        send_item(it);
    endtask

    task automatic send_unknown();
        send_item(random_item(KIND_UNKNOWN));
    endtask

    // Stops the sender and waits for every outstanding result, then lets
    // the block finish any load or rewind that is still in flight.
    task automatic settle_block();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the predictor copy follows once the write is taken.
    task automatic write_reg(logic [2:0] index, logic [23:0] data);
        cfg_index <= index;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        regs_written++;
        case (index)
            REG_PLAY_RATE:    rate_q = $signed({{8{data[23]}}, data});
            REG_LEVEL_GAIN:   gain_q = data[15:0];
            REG_LEFT_WEIGHT:  left_wt_q = data[15:0];
            REG_RIGHT_WEIGHT: right_wt_q = data[15:0];
            REG_STEREO_MODE:  stereo_q = data[0];
            REG_FRAME_COUNT:  count_q = data[16:0];
            default:          ;
        endcase
    endtask

    // Quiesces the block and writes the whole register set. Bits above each
    // register's width carry random junk that the block must drop.
    task automatic apply_setup(int rate, int unsigned gain, int unsigned left_wt,
                               int unsigned right_wt, bit stereo, int unsigned count);
        logic [31:0] junk;
        junk = $urandom();
        settle_block();
        write_reg(REG_PLAY_RATE, rate[23:0]);
        write_reg(REG_LEVEL_GAIN, {junk[7:0], gain[15:0]});
        write_reg(REG_LEFT_WEIGHT, {junk[15:8], left_wt[15:0]});
        write_reg(REG_RIGHT_WEIGHT, {junk[23:16], right_wt[15:0]});
        write_reg(REG_STEREO_MODE, {junk[31:9], stereo});
        write_reg(REG_FRAME_COUNT, {junk[6:0], count[16:0]});
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stall
    // ------------------------------------------------------------------

    // A result is taken at an edge where valid is high and stall is low.
    // Both are read before this edge's updates land, so sampling here does
    // not race the block. The next stall value is chosen in the same place.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no tick waiting for it");
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                ticks_checked++;
                if (want.ended)
                begin
                    ended_seen++;
                end
                if (result.left_out !== want.left_out)
                begin
                    $error("left_out expected %0d got %0d", want.left_out, result.left_out);
                    errors++;
                end
                if (result.right_out !== want.right_out)
                begin
                    $error("right_out expected %0d got %0d", want.right_out, result.right_out);
                    errors++;
                end
                if (result.current_sample !== want.current_sample)
                begin
                    $error("current_sample expected %0d got %0d",
                           want.current_sample, result.current_sample);
                    errors++;
                end
                if (result.ended !== want.ended)
                begin
                    $error("ended expected %0d got %0d", want.ended, result.ended);
                    errors++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset the table is empty, so a tick is already off
    // the end. An item of unknown kind and writes to indexes past the
    // register list must change nothing.
    task automatic test_reset_defaults();
        send_tick(16'sd100, -16'sd200);
        send_unknown();
        settle_block();
        write_reg(REG_BEYOND_LO, 24'($urandom()));
        write_reg(REG_BEYOND_HI, 24'hFFFFFF);
        send_tick(-16'sd1, 16'sd1);
    endtask

    task automatic test_directed_extremes();
        // Full gain and full pan weights on full-scale samples drive both
        // channels into saturation, high and low; the fifth tick runs off
        // the end of a four-frame table.
        apply_setup(65536, 65535, 32768, 32768, 1'b1, 4);
        send_load(16'd0, 16'sh7FFF, 16'sh8000);
        send_load(16'd1, 16'sh8000, 16'sh7FFF);
        send_load(16'd2, 16'sd1, -16'sd1);
        send_load(16'd3, 16'sd0, 16'sd0);
        send_rewind(16'd0);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sd0, 16'sd0);
        send_tick(-16'sd1, 16'sd1);
        send_tick(16'sd123, -16'sd456);

        // Unity gain and half weight put a sample of one exactly on a
        // rounding half: plus one rounds up to one, minus one up to zero.
        // Playing in reverse, the fourth tick drops below frame zero.
        apply_setup(-65536, 4096, 16384, 16384, 1'b1, 4);
        send_rewind(16'd2);
        repeat (4) send_tick(16'sd0, 16'sd0);

        // Zero rate holds the playhead; zero weights and mono mode pass the
        // mix values through untouched.
        apply_setup(0, 4096, 0, 0, 1'b0, 4);
        send_rewind(16'd3);
        repeat (2) send_tick(pick_sample(), pick_sample());

        // A frame count beyond the store acts as a full store. The top frame
        // is played, then the largest forward step leaves the table; the
        // largest reverse step brings the playhead back in from there.
        apply_setup(RATE_MAX, 4096, 23170, 23170, 1'b1, 131071);
        send_rewind(16'hFFFF);
        repeat (2) send_tick(pick_sample(), pick_sample());
        apply_setup(RATE_MIN, 4096, 23170, 23170, 1'b1, 131071);
        repeat (2) send_tick(pick_sample(), pick_sample());
    endtask

    // Random playback sessions: each writes a fresh register set, loads a
    // small table, rewinds and plays a run of ticks, with a few stray loads,
    // rewinds and unknown items mixed in. Every session starts from a
    // drained block, so the sender waits on all outstanding results often.
    task automatic test_random_playback(int target);
        int stop_at;
        int rate;
        int unsigned gain;
        int unsigned count;
        int unsigned span;
        int unsigned start;
        int table_len;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(9))
                0: rate = 0;
                1: rate = RATE_MAX;
                2: rate = RATE_MIN;
                3, 4: rate = -int'($urandom_range(1, 262144));
                default: rate = $urandom_range(1, 262144);
            endcase
            case ($urandom_range(9))
                0: gain = 0;
                1: gain = 65535;
                default: gain = $urandom_range(1024, 12288);
            endcase
            case ($urandom_range(19))
                0: count = 0;
                1: count = MAX_FRAMES;
                2: count = $urandom_range(0, 131071);
                default: count = $urandom_range(1, 48);
            endcase
            apply_setup(rate, gain, $urandom_range(0, 32768), $urandom_range(0, 32768),
                        1'($urandom_range(1)), count);

            // Most sessions play a table that was loaded in full; large
            // counts rely on the frame-on-demand loads in send_tick.
            span = (count > MAX_FRAMES) ? MAX_FRAMES : count;
            table_len = (span < 48) ? span : 48;
            for (int i = 0; i < table_len; i++)
            begin
                send_load(i[15:0], pick_sample(), pick_sample());
            end

            if (span == 0 || $urandom_range(3) == 0)
            begin
                start = $urandom_range(0, 65535);
            end
            else if (rate < 0)
            begin
                start = $urandom_range(span / 2, span - 1);
            end
            else
            begin
                start = $urandom_range(0, (span - 1) / 2);
            end
            send_rewind(start[15:0]);

            repeat ($urandom_range(4, 40))
            begin
                case ($urandom_range(24))
                    0: send_unknown();
                    1: send_rewind(16'($urandom()));
                    2: send_load(16'($urandom()), pick_sample(), pick_sample());
                    default: send_tick(pick_sample(), pick_sample());
                endcase
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Slow receiver first, then a slow sender, then both at full speed.
        send_idle_pct = 12;
        recv_stall_pct = 86;
        test_reset_defaults();
        test_directed_extremes();
        test_random_playback(250);

        send_idle_pct = 86;
        recv_stall_pct = 12;
        test_random_playback(250);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_playback(250);

        settle_block();
        $display("Run covered %0d items and %0d register writes; %0d ticks checked,",
                 items_sent, regs_written, ticks_checked);
        $display("%0d of them off the table, under three sender and receiver idle mixes.",
                 ended_seen);
        if (errors == 0)
        begin
            $display("PASS sample_playback_voice_unit");
        end
        else
        begin
            $display("FAIL sample_playback_voice_unit");
        end
        $finish;
    end

    // Watchdog: a lost result or a handshake that never completes ends the
    // run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles without finishing.", cycle_count);
        $display("FAIL sample_playback_voice_unit");
        $finish;
    end

endmodule
